[src/adc_sample_map_and_average_defines.svh]
// Assertion macros shared by the sample map and average block.
`ifndef ADC_SAMPLE_MAP_AND_AVERAGE_DEFINES_SVH
`define ADC_SAMPLE_MAP_AND_AVERAGE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define ASMA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASMA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/asma_pkg.sv]
package asma_pkg;

  // Field widths
  localparam int IDX_W      = 3;
  localparam int RAW_W      = 24;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 2;
  localparam int PROD_W     = RAW_W + VAL_W;
  localparam int IN_DATA_W  = 88;  // raw + two bounds, whole bytes
  localparam int IN_USER_W  = 4;
  localparam int OUT_DATA_W = 32;
  localparam int OUT_USER_W = 2;

  // Converter full-scale code, also the map divisor
  localparam logic [RAW_W-1:0] FULL_SCALE = 24'hFFFFFF;

  typedef enum logic [STAT_W-1:0] {
    STATUS_NEW     = 2'd0,
    STATUS_HELD    = 2'd1,
    STATUS_INVALID = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_CDIV,
    S_MAP,
    S_UPD,
    S_PREP,
    S_ADIV,
    S_WB,
    S_OUT
  } state_t;

endpackage

[src/asma_ram.sv]
module asma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/adc_sample_map_and_average.sv]
// Per-sensor sample map and moving average. One request at a time: a request
// is taken when the block is idle, and a finished result waits in the output
// register so the next request can be taken meanwhile. A rejected request
// goes from the read state straight to output and an outlier from the check
// state; a new sample then runs the map divide, map, window update, average
// divide and write-back. SUM_W = 33 + max(1, clog2(WINDOW_LENGTH)), so at
// least 34. The average is formed by a one-bit-per-cycle restoring divider
// over the running sum; the map divide by full scale is done by add-and-fold.
// Window values live in one RAM and the per-sensor state (position, fill,
// sum, last average) in a second; per-sensor valid flops make a never-written
// sensor read as all zero, so no clearing pass runs after reset.
`include "adc_sample_map_and_average_defines.svh"

module adc_sample_map_and_average #(
  parameter int SENSOR_COUNT  = 8,
  parameter int WINDOW_LENGTH = 8
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // raw_sample[23:0], map_low[55:24], map_top[87:56]
  input  logic [asma_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // sensor_index[2:0], gain_negative[3]
  input  logic [asma_pkg::IN_USER_W-1:0]   s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // value[31:0]
  output logic [asma_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // status[1:0]
  output logic [asma_pkg::OUT_USER_W-1:0]  m_axis_tuser
);

  localparam int SIDX_W = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int PW     = (WINDOW_LENGTH > 1) ? $clog2(WINDOW_LENGTH) : 1;
  localparam int FC_W   = $clog2(WINDOW_LENGTH + 1);
  localparam int SUM_W  = 33 + PW;
  localparam int ST_W   = PW + FC_W + SUM_W + asma_pkg::VAL_W;
  localparam int WDEPTH = SENSOR_COUNT * WINDOW_LENGTH;
  localparam int WAW    = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int DCNT_W = $clog2(SUM_W);
  localparam int VW     = asma_pkg::VAL_W;
  localparam int RW     = asma_pkg::RAW_W;
  localparam int PRW    = asma_pkg::PROD_W;

  asma_pkg::state_t  state, state_next;
  asma_pkg::status_t res_status;

  // Request registers
  logic [asma_pkg::IDX_W-1:0] idx;
  logic [RW-1:0]              raw;
  logic [VW-1:0]              lo, hi;
  logic                       bad, outlier;
  logic [SIDX_W-1:0]          sidx;

  // Map datapath
  logic [VW:0]   diff;
  logic [VW-1:0] dmag;
  logic          dneg;
  logic [PRW-1:0] prod, crem;
  logic [VW-1:0] cq, ch;
  logic          cdiv_done;
  logic [VW+1:0] q_ext, q_signed, map_sum;
  logic [VW-1:0] mapped;

  // Per-sensor state working copy
  logic [PW-1:0]    pos, cur_pos, pos_upd;
  logic [FC_W-1:0]  fill, cur_fill, fill_upd;
  logic [SUM_W-1:0] sum, cur_sum, sum_upd, old_ext, map_ext;
  logic [VW-1:0]    cur_last, res_value;
  logic             full;
  logic [ST_W-1:0]  st_rdata, st_word, st_wdata;
  logic [SENSOR_COUNT-1:0] st_valid;

  // Window RAM
  logic [WAW-1:0] win_addr, win_addr_c;
  logic [VW-1:0]  win_rdata;

  // Average divider
  logic [SUM_W-1:0]  dq;
  logic [FC_W-1:0]   drem, drem_next;
  logic [FC_W:0]     dshift;
  logic              dge, sneg;
  logic [DCNT_W-1:0] dcnt;
  logic [VW-1:0]     avg;

  // Control
  logic s_accept, st_re, st_we, win_re, win_we, out_load;

  assign s_accept = s_axis_tvalid && s_axis_tready;
  assign sidx     = SIDX_W'(idx);

  // Mapping arithmetic
  assign diff      = {hi[VW-1], hi} - {lo[VW-1], lo};
  assign prod      = raw * dmag;
  assign ch        = crem[PRW-1:RW];
  assign cdiv_done = (ch == '0) && (crem != PRW'(asma_pkg::FULL_SCALE));
  assign q_ext     = {2'b00, cq};
  assign q_signed  = dneg ? (~q_ext + 1'b1) : q_ext;
  assign map_sum   = {{2{lo[VW-1]}}, lo} + q_signed;

  // Current state word; unwritten sensors read as zero
  assign st_word  = st_valid[sidx] ? st_rdata : '0;
  assign cur_last = st_word[VW-1:0];
  assign cur_sum  = st_word[VW +: SUM_W];
  assign cur_fill = st_word[VW+SUM_W +: FC_W];
  assign cur_pos  = st_word[VW+SUM_W+FC_W +: PW];
  assign st_wdata = {pos, fill, sum, avg};

  assign win_addr_c = WAW'(int'(idx) * WINDOW_LENGTH + int'(cur_pos));

  // Window update
  assign full     = (fill == FC_W'(WINDOW_LENGTH));
  assign old_ext  = {{(SUM_W-VW){win_rdata[VW-1]}}, win_rdata};
  assign map_ext  = {{(SUM_W-VW){mapped[VW-1]}}, mapped};
  assign sum_upd  = sum - (full ? old_ext : '0) + map_ext;
  assign fill_upd = full ? fill : fill + 1'b1;
  assign pos_upd  = (pos == PW'(WINDOW_LENGTH - 1)) ? '0 : pos + 1'b1;

  // Restoring divider step
  assign dshift    = {drem, dq[SUM_W-1]};
  assign dge       = dshift >= {1'b0, fill};
  assign drem_next = dge ? FC_W'(dshift - {1'b0, fill}) : FC_W'(dshift);
  assign avg       = sneg ? (~dq[VW-1:0] + 1'b1) : dq[VW-1:0];

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      asma_pkg::S_IDLE:  if (s_accept) state_next = asma_pkg::S_READ;
      asma_pkg::S_READ:  state_next = bad ? asma_pkg::S_OUT : asma_pkg::S_CHECK;
      asma_pkg::S_CHECK: state_next = outlier ? asma_pkg::S_OUT : asma_pkg::S_CDIV;
      asma_pkg::S_CDIV:  if (cdiv_done) state_next = asma_pkg::S_MAP;
      asma_pkg::S_MAP:   state_next = asma_pkg::S_UPD;
      asma_pkg::S_UPD:   state_next = asma_pkg::S_PREP;
      asma_pkg::S_PREP:  state_next = asma_pkg::S_ADIV;
      asma_pkg::S_ADIV:  if (dcnt == DCNT_W'(SUM_W - 1)) state_next = asma_pkg::S_WB;
      asma_pkg::S_WB:    state_next = asma_pkg::S_OUT;
      asma_pkg::S_OUT:   if (out_load) state_next = asma_pkg::S_IDLE;
      default:           state_next = asma_pkg::S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready = 1'b0;
    st_re         = 1'b0;
    st_we         = 1'b0;
    win_re        = 1'b0;
    win_we        = 1'b0;
    out_load      = 1'b0;
    case (state)
      asma_pkg::S_IDLE:  s_axis_tready = 1'b1;
      asma_pkg::S_READ:  st_re = 1'b1;
      asma_pkg::S_CHECK: win_re = 1'b1;
      asma_pkg::S_UPD:   win_we = 1'b1;
      asma_pkg::S_WB:    st_we = 1'b1;
      asma_pkg::S_OUT:   out_load = !m_axis_tvalid || m_axis_tready;
      default:           s_axis_tready = 1'b0;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= asma_pkg::S_IDLE;
      st_valid      <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      if (st_we) begin
        st_valid[sidx] <= 1'b1;
      end
      if (out_load) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    case (state)
      asma_pkg::S_IDLE: begin
        if (s_accept) begin
          idx <= s_axis_tuser[2:0];
          raw <= s_axis_tdata[23:0];
          lo  <= s_axis_tdata[55:24];
          hi  <= s_axis_tdata[87:56];
          bad <= (s_axis_tdata[55:24] == s_axis_tdata[87:56]) || s_axis_tuser[3] ||
                 (int'(s_axis_tuser[2:0]) >= SENSOR_COUNT);
        end
      end
      asma_pkg::S_READ: begin
        dneg       <= diff[VW];
        dmag       <= diff[VW] ? (~diff[VW-1:0] + 1'b1) : diff[VW-1:0];
        outlier    <= (raw == '0) || (raw == asma_pkg::FULL_SCALE);
        res_value  <= '0;
        res_status <= asma_pkg::STATUS_INVALID;
      end
      asma_pkg::S_CHECK: begin
        pos        <= cur_pos;
        fill       <= cur_fill;
        sum        <= cur_sum;
        res_value  <= cur_last;
        res_status <= asma_pkg::STATUS_HELD;
        crem       <= prod;
        cq         <= '0;
        win_addr   <= win_addr_c;
      end
      asma_pkg::S_CDIV: begin
        // x = h*2^24 + l = h*(2^24-1) + (h + l)
        if (ch != '0) begin
          cq   <= cq + ch;
          crem <= PRW'(crem[RW-1:0]) + PRW'(ch);
        end else if (!cdiv_done) begin
          cq   <= cq + 1'b1;
          crem <= '0;
        end
      end
      asma_pkg::S_MAP: begin
        mapped <= map_sum[VW-1:0];
      end
      asma_pkg::S_UPD: begin
        sum  <= sum_upd;
        fill <= fill_upd;
        pos  <= pos_upd;
      end
      asma_pkg::S_PREP: begin
        sneg <= sum[SUM_W-1];
        dq   <= sum[SUM_W-1] ? (~sum + 1'b1) : sum;
        drem <= '0;
        dcnt <= '0;
      end
      asma_pkg::S_ADIV: begin
        dq   <= {dq[SUM_W-2:0], dge};
        drem <= drem_next;
        dcnt <= dcnt + 1'b1;
      end
      asma_pkg::S_WB: begin
        res_value  <= avg;
        res_status <= asma_pkg::STATUS_NEW;
      end
      asma_pkg::S_OUT: begin
        if (out_load) begin
          m_axis_tdata <= res_value;
          m_axis_tuser <= res_status;
        end
      end
      default: begin
        res_status <= res_status;
      end
    endcase
  end

  // Window values, one row of WINDOW_LENGTH per sensor
  asma_ram #(
    .WIDTH (VW),
    .DEPTH (WDEPTH)
  ) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_addr),
    .wdata (mapped),
    .re    (win_re),
    .raddr (win_addr_c),
    .rdata (win_rdata)
  );

  // Per-sensor position, fill, running sum and last average
  asma_ram #(
    .WIDTH (ST_W),
    .DEPTH (SENSOR_COUNT)
  ) u_st_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (sidx),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (sidx),
    .rdata (st_rdata)
  );

  // Checks
  `ASMA_ASSERT_IMP(a_invalid_zero, m_axis_tvalid && (m_axis_tuser == asma_pkg::STATUS_INVALID), m_axis_tdata == '0, "invalid request returned a nonzero value")
  `ASMA_ASSERT_NXT(a_win_then_avg, win_we, state == asma_pkg::S_PREP, "window write not followed by average")
  `ASMA_ASSERT_IMP(a_div_nonzero, state == asma_pkg::S_ADIV, fill != '0, "average divider run with empty window")
  `ASMA_ASSERT_NXT(a_load_shows, out_load, m_axis_tvalid && (state == asma_pkg::S_IDLE), "loaded result not presented")

endmodule

[sim/tb_adc_sample_map_and_average.sv]
module tb_adc_sample_map_and_average;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SENSORS      = 8;
  localparam int WINDOW       = 8;
  localparam int RANDOM_ITEMS = 1200;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_AT      = 1000;  // requests taken before the long output stall
  localparam int HOLD_CYCLES  = 600;

  localparam logic signed [asma_pkg::VAL_W-1:0] Q_MIN = 32'sh8000_0000;
  localparam logic signed [asma_pkg::VAL_W-1:0] Q_MAX = 32'sh7fff_ffff;

  typedef logic [asma_pkg::RAW_W-1:0] raw_code_t;
  typedef logic [asma_pkg::IDX_W-1:0] sensor_sel_t;

  // one request as seen on the input stream
  typedef struct {
    logic [asma_pkg::IDX_W-1:0]        sensor;
    logic [asma_pkg::RAW_W-1:0]        raw;
    logic signed [asma_pkg::VAL_W-1:0] lo;
    logic signed [asma_pkg::VAL_W-1:0] hi;
    logic                              gain_neg;
  } sample_req_t;

  typedef struct {
    logic [asma_pkg::VAL_W-1:0] value;
    asma_pkg::status_t          status;
  } avg_answer_t;

  // Per-sensor window model plus the queue of answers still owed by the block
  class average_tracker;
    logic signed [asma_pkg::VAL_W-1:0] window_val[SENSORS][WINDOW];
    int unsigned                       wr_pos[SENSORS];
    int unsigned                       filled[SENSORS];
    longint                            win_sum[SENSORS];
    logic signed [asma_pkg::VAL_W-1:0] last_avg[SENSORS];
    bit                                have_avg[SENSORS];
    avg_answer_t                       expected_answers[$];
    int                                mismatch_count;

    function new();
      for (int s = 0; s < SENSORS; s++) begin
        wr_pos[s]   = 0;
        filled[s]   = 0;
        win_sum[s]  = 0;
        last_avg[s] = '0;
        have_avg[s] = 1'b0;
      end
      mismatch_count = 0;
    endfunction

    function void note_sample(sample_req_t r);
      avg_answer_t ans;
      longint      lo_l;
      longint      hi_l;
      longint      mapped;
      longint      avg;
      int unsigned s;
      int unsigned p;
      lo_l = longint'(r.lo);
      hi_l = longint'(r.hi);
      s    = int'(r.sensor);
      if (r.lo == r.hi || r.gain_neg) begin
        ans.value  = '0;
        ans.status = asma_pkg::STATUS_INVALID;
      end else if (r.raw == '0 || r.raw == asma_pkg::FULL_SCALE) begin
        // outlier: hold the last average, zero before the first one
        ans.value  = have_avg[s] ? last_avg[s] : '0;
        ans.status = asma_pkg::STATUS_HELD;
      end else begin
        mapped = lo_l + (longint'(r.raw) * (hi_l - lo_l)) /
                 longint'(asma_pkg::FULL_SCALE);
        p = wr_pos[s];
        if (filled[s] >= WINDOW)
          win_sum[s] -= longint'(window_val[s][p]);
        else
          filled[s]++;
        window_val[s][p] = mapped[asma_pkg::VAL_W-1:0];
        win_sum[s] += mapped;
        wr_pos[s] = (p + 1 >= WINDOW) ? 0 : p + 1;
        avg = win_sum[s] / longint'(filled[s]);
        last_avg[s] = avg[asma_pkg::VAL_W-1:0];
        have_avg[s] = 1'b1;
        ans.value   = avg[asma_pkg::VAL_W-1:0];
        ans.status  = asma_pkg::STATUS_NEW;
      end
      expected_answers.push_back(ans);
    endfunction

    function void check_answer(logic [asma_pkg::VAL_W-1:0] value,
                               logic [asma_pkg::STAT_W-1:0] status);
      avg_answer_t exp_ans;
      if (expected_answers.size() == 0) begin
        $error("unexpected result: value %0h status %0d", value, status);
        mismatch_count++;
        return;
      end
      exp_ans = expected_answers.pop_front();
      if (value !== exp_ans.value) begin
        $error("value: expected %0d, got %0d", $signed(exp_ans.value), $signed(value));
        mismatch_count++;
      end
      if (status !== exp_ans.status) begin
        $error("status: expected %0d, got %0d", exp_ans.status, status);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            s_axis_tvalid = 1'b0;
  logic                            s_axis_tready;
  logic [asma_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;   // raw_sample, map_low, map_top
  logic [asma_pkg::IN_USER_W-1:0]  s_axis_tuser = '0;   // sensor_index, gain_negative
  logic                            m_axis_tvalid;
  logic                            m_axis_tready = 1'b0;
  logic [asma_pkg::OUT_DATA_W-1:0] m_axis_tdata;         // value
  logic [asma_pkg::OUT_USER_W-1:0] m_axis_tuser;         // status

  average_tracker tracker = new();
  int tx_idle_pct = 18;
  int rx_idle_pct = 79;
  int samples_sent = 0;
  int cycle_count = 0;

  always #1 clk = ~clk;

  adc_sample_map_and_average #(
    .SENSOR_COUNT (SENSORS),
    .WINDOW_LENGTH(WINDOW)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  function automatic sample_req_t make_req(logic [asma_pkg::IDX_W-1:0] sensor,
                                           logic [asma_pkg::RAW_W-1:0] raw,
                                           logic signed [asma_pkg::VAL_W-1:0] lo,
                                           logic signed [asma_pkg::VAL_W-1:0] hi,
                                           logic gain_neg);
    sample_req_t r;
    r.sensor   = sensor;
    r.raw      = raw;
    r.lo       = lo;
    r.hi       = hi;
    r.gain_neg = gain_neg;
    return r;
  endfunction

  // Mostly in-range samples with usable bounds so windows fill and wrap;
  // the rest are outliers, rejected requests and fully random noise.
  function automatic sample_req_t random_req();
    sample_req_t r;
    int          pick;
    pick       = $urandom_range(99);
    r.sensor   = sensor_sel_t'($urandom_range(SENSORS - 1));
    r.gain_neg = 1'b0;
    r.raw      = raw_code_t'($urandom_range(1, int'(asma_pkg::FULL_SCALE) - 1));
    case ($urandom_range(3))
      0: begin
        r.lo = $urandom;
        r.hi = $urandom;
      end
      1: begin
        r.lo = $urandom_range(1) ? Q_MIN : Q_MAX;
        r.hi = (r.lo == Q_MIN) ? Q_MAX : Q_MIN;
      end
      2: begin
        r.lo = $urandom;
        r.hi = r.lo + $signed($urandom_range(65535)) - 32'sd32768;
      end
      default: begin
        r.lo = $signed($urandom_range(2097151)) - 32'sd1048576;
        r.hi = $signed($urandom_range(2097151)) - 32'sd1048576;
      end
    endcase
    if (pick < 8) begin
      r.raw = $urandom_range(1) ? asma_pkg::FULL_SCALE : '0;
    end else if (pick < 12) begin
      r.hi = r.lo;
    end else if (pick < 16) begin
      r.gain_neg = 1'b1;
    end else if (pick < 20) begin
      r.raw      = raw_code_t'($urandom);
      r.lo       = $urandom;
      r.hi       = $urandom;
      r.gain_neg = 1'($urandom_range(1));
    end
    return r;
  endfunction

  // Offer one request; returns once the block has taken it
  task automatic send_sample(input sample_req_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {r.hi, r.lo, r.raw};
    s_axis_tuser  <= {r.gain_neg, r.sensor};
    do @(posedge clk); while (!s_axis_tready);
    tracker.note_sample(r);
    samples_sent++;
  endtask

  // Result side: check on handshake, then pick next ready
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        tracker.check_answer(m_axis_tdata, m_axis_tuser);
      if (!hold_done && samples_sent >= HOLD_AT) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed: rejects, outliers before and after an average, extreme bounds
    send_sample(make_req(3'd0, '0, Q_MIN, Q_MAX, 1'b0));
    send_sample(make_req(3'd0, asma_pkg::FULL_SCALE, 32'sd0, 32'sh10000, 1'b0));
    send_sample(make_req(3'd1, 24'h123456, 32'sh50000, 32'sh50000, 1'b0));
    send_sample(make_req(3'd1, 24'h123456, 32'sd0, 32'sh10000, 1'b1));
    send_sample(make_req(3'd2, '0, 32'sd7, 32'sd7, 1'b1));
    send_sample(make_req(3'd1, 24'h000001, Q_MIN, Q_MAX, 1'b0));
    send_sample(make_req(3'd1, asma_pkg::FULL_SCALE - 24'd1, Q_MAX, Q_MIN, 1'b0));
    send_sample(make_req(3'd1, asma_pkg::FULL_SCALE, 32'sd0, 32'sd1, 1'b0));
    send_sample(make_req(3'd2, 24'h800000, Q_MIN, Q_MAX, 1'b0));
    // fill and wrap one window with values near both ends of the range
    for (int k = 0; k < 10; k++)
      send_sample(make_req(3'd3,
                           (k % 3 == 0) ? 24'h000001 : asma_pkg::FULL_SCALE - 24'd1,
                           Q_MAX, Q_MIN, 1'b0));
    send_sample(make_req(3'd3, asma_pkg::FULL_SCALE, 32'sd0, 32'sd5, 1'b0));
    send_sample(make_req(3'd3, 24'h400000, Q_MIN, Q_MIN, 1'b0));
    send_sample(make_req(3'd7, 24'h000001, -32'sd3, 32'sd3, 1'b0));

    // random, three idle profiles
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 400) begin
        tx_idle_pct = 79;
        rx_idle_pct = 18;
      end else if (n == 800) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_sample(random_req());
    end
    s_axis_tvalid <= 1'b0;

    // drain
    while (tracker.expected_answers.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule
